FILE: src/bmc_pkg.sv
// ----------------------------------------------------------------------------
// bmc_pkg: shared types and constants of the bracket match checker
// Bracket kind codes, character decoding and the illegal closer scores.
// ----------------------------------------------------------------------------
package bmc_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PAREN  = 2'd0;
    localparam kind_t KIND_SQUARE = 2'd1;
    localparam kind_t KIND_CURLY  = 2'd2;
    localparam kind_t KIND_ANGLE  = 2'd3;

    localparam logic [7:0] CHAR_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CHAR_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CHAR_OPEN_ANGLE   = 8'h3C;
    localparam logic [7:0] CHAR_CLOSE_ANGLE  = 8'h3E;

    localparam int ERR_SCORE_W = 15;
    localparam int SCORE_W     = 64;
    localparam int COUNT_W     = 7;

    localparam logic [ERR_SCORE_W-1:0] SCORE_PAREN  = 15'd3;
    localparam logic [ERR_SCORE_W-1:0] SCORE_SQUARE = 15'd57;
    localparam logic [ERR_SCORE_W-1:0] SCORE_CURLY  = 15'd1197;
    localparam logic [ERR_SCORE_W-1:0] SCORE_ANGLE  = 15'd25137;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } kind_hit_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        kind_t kind;
    } stack_op_t;

    function automatic kind_hit_t opener_decode(logic [7:0] c);
        kind_hit_t r;
        r = '0;
        case (c)
            CHAR_OPEN_PAREN:  r = '{hit: 1'b1, kind: KIND_PAREN};
            CHAR_OPEN_SQUARE: r = '{hit: 1'b1, kind: KIND_SQUARE};
            CHAR_OPEN_CURLY:  r = '{hit: 1'b1, kind: KIND_CURLY};
            CHAR_OPEN_ANGLE:  r = '{hit: 1'b1, kind: KIND_ANGLE};
            default:          r = '0;
        endcase
        return r;
    endfunction

    function automatic kind_hit_t closer_decode(logic [7:0] c);
        kind_hit_t r;
        r = '0;
        case (c)
            CHAR_CLOSE_PAREN:  r = '{hit: 1'b1, kind: KIND_PAREN};
            CHAR_CLOSE_SQUARE: r = '{hit: 1'b1, kind: KIND_SQUARE};
            CHAR_CLOSE_CURLY:  r = '{hit: 1'b1, kind: KIND_CURLY};
            CHAR_CLOSE_ANGLE:  r = '{hit: 1'b1, kind: KIND_ANGLE};
            default:           r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [ERR_SCORE_W-1:0] illegal_score(kind_t k);
        logic [ERR_SCORE_W-1:0] s;
        s = '0;
        case (k)
            KIND_PAREN:  s = SCORE_PAREN;
            KIND_SQUARE: s = SCORE_SQUARE;
            KIND_CURLY:  s = SCORE_CURLY;
            KIND_ANGLE:  s = SCORE_ANGLE;
            default:     s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: src/bmc_cell.sv
// ----------------------------------------------------------------------------
// bmc_cell: one entry of the opener stack
// Takes the entry above it on a push, the entry below it on a pop.
// ----------------------------------------------------------------------------
module bmc_cell
    import bmc_pkg::*;
(
    input  logic      clk,
    input  stack_op_t op,
    input  kind_t     upper,
    input  kind_t     lower,
    output kind_t     kind
);

    kind_t kind_reg;
    kind_t kind_next;

    always_comb
    begin
        kind_next = kind_reg;
        if (op.push)
        begin
            kind_next = upper;
        end
        else if (op.pop)
        begin
            kind_next = lower;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    assign kind = kind_reg;

endmodule

FILE: src/bmc_stack.sv
// ----------------------------------------------------------------------------
// bmc_stack: opener stack as a chain of cells
// Cell zero holds the top; pushes shift the chain down, pops shift it up.
// ----------------------------------------------------------------------------
module bmc_stack
    import bmc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic      clk,
    input  stack_op_t op,
    output kind_t     top
);

    kind_t cell_kind [STACK_DEPTH];

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        kind_t upper;
        kind_t lower;

        if (i == 0)
        begin : g_top
            assign upper = op.kind;
        end
        else
        begin : g_mid_up
            assign upper = cell_kind[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign lower = cell_kind[i];
        end
        else
        begin : g_mid_down
            assign lower = cell_kind[i+1];
        end

        bmc_cell u_cell
        (
            .clk   (clk),
            .op    (op),
            .upper (upper),
            .lower (lower),
            .kind  (cell_kind[i])
        );
    end

    assign top = cell_kind[0];

endmodule

FILE: src/bracket_match_checker.sv
// ----------------------------------------------------------------------------
// bracket_match_checker: balanced bracket checker for one line of text
// Matches openers and closers of four kinds and scores each line at its end.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload
// input    in_valid / in_stall   char_in, line_end
// output   out_valid / out_stall is_corrupted, bad_closer, error_score,
//                                completion_score, open_count, stack_overflow
//
// A character that does not end a line is taken in ST_IDLE, and the next one
// can follow it. A line-end transaction enters the score walk, which pops one
// cell of the stack chain per cycle and then loads the result register.
// On a corrupted line the walk pops nothing and only loads the result register.
// The walk waits at its end while a previous result is still stalled.
// Reset clears all control state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module bracket_match_checker
    import bmc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             char_in,
    input  logic                   line_end,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   is_corrupted,
    output logic [1:0]             bad_closer,
    output logic [ERR_SCORE_W-1:0] error_score,
    output logic [SCORE_W-1:0]     completion_score,
    output logic [COUNT_W-1:0]     open_count,
    output logic                   stack_overflow
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam logic [LVL_W-1:0] DEPTH_L = LVL_W'(STACK_DEPTH);

    typedef enum logic {ST_IDLE, ST_WALK} state_t;

    state_t                 state_reg, state_next;
    logic [LVL_W-1:0]       level_reg, level_next;
    logic [LVL_W-1:0]       walk_cnt_reg, walk_cnt_next;
    logic                   corrupt_reg, corrupt_next;
    kind_t                  bad_reg, bad_next;
    logic                   overflow_reg, overflow_next;
    logic [SCORE_W-1:0]     score_reg, score_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_corrupt_reg, out_corrupt_next;
    kind_t                  out_bad_reg, out_bad_next;
    logic [ERR_SCORE_W-1:0] out_err_reg, out_err_next;
    logic [SCORE_W-1:0]     out_score_reg, out_score_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;
    logic                   out_ovf_reg, out_ovf_next;

    stack_op_t op;
    kind_t     top;
    kind_hit_t open_dec;
    kind_hit_t close_dec;
    logic      in_accept;

    bmc_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack
    (
        .clk (clk),
        .op  (op),
        .top (top)
    );

    always_comb
    begin
        state_next       = state_reg;
        level_next       = level_reg;
        walk_cnt_next    = walk_cnt_reg;
        corrupt_next     = corrupt_reg;
        bad_next         = bad_reg;
        overflow_next    = overflow_reg;
        score_next       = score_reg;
        out_valid_next   = out_valid_reg;
        out_corrupt_next = out_corrupt_reg;
        out_bad_next     = out_bad_reg;
        out_err_next     = out_err_reg;
        out_score_next   = out_score_reg;
        out_count_next   = out_count_reg;
        out_ovf_next     = out_ovf_reg;
        op               = '0;
        open_dec         = opener_decode(char_in);
        close_dec        = closer_decode(char_in);
        in_accept        = in_valid && (state_reg == ST_IDLE);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!corrupt_reg)
                    begin
                        if (open_dec.hit)
                        begin
                            if (level_reg < DEPTH_L)
                            begin
                                op.push    = 1'b1;
                                op.kind    = open_dec.kind;
                                level_next = level_reg + 1'b1;
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        else if (close_dec.hit)
                        begin
                            if ((level_reg != '0) && (top == close_dec.kind))
                            begin
                                op.pop     = 1'b1;
                                level_next = level_reg - 1'b1;
                            end
                            else
                            begin
                                corrupt_next = 1'b1;
                                bad_next     = close_dec.kind;
                            end
                        end
                    end
                    if (line_end)
                    begin
                        state_next    = ST_WALK;
                        walk_cnt_next = corrupt_next ? '0 : level_next;
                        score_next    = '0;
                    end
                end
            end
            ST_WALK:
            begin
                if (walk_cnt_reg != '0)
                begin
                    op.pop        = 1'b1;
                    score_next    = (score_reg << 2) + score_reg
                                  + SCORE_W'(top) + SCORE_W'(1);
                    walk_cnt_next = walk_cnt_reg - 1'b1;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_corrupt_next = corrupt_reg;
                    out_bad_next     = corrupt_reg ? bad_reg : KIND_PAREN;
                    out_err_next     = corrupt_reg ? illegal_score(bad_reg) : '0;
                    out_score_next   = score_reg;
                    out_count_next   = COUNT_W'(level_reg);
                    out_ovf_next     = overflow_reg;
                    level_next       = '0;
                    corrupt_next     = 1'b0;
                    bad_next         = KIND_PAREN;
                    overflow_next    = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            level_reg       <= '0;
            walk_cnt_reg    <= '0;
            corrupt_reg     <= 1'b0;
            bad_reg         <= KIND_PAREN;
            overflow_reg    <= 1'b0;
            score_reg       <= '0;
            out_valid_reg   <= 1'b0;
            out_corrupt_reg <= 1'b0;
            out_bad_reg     <= KIND_PAREN;
            out_err_reg     <= '0;
            out_score_reg   <= '0;
            out_count_reg   <= '0;
            out_ovf_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            level_reg       <= level_next;
            walk_cnt_reg    <= walk_cnt_next;
            corrupt_reg     <= corrupt_next;
            bad_reg         <= bad_next;
            overflow_reg    <= overflow_next;
            score_reg       <= score_next;
            out_valid_reg   <= out_valid_next;
            out_corrupt_reg <= out_corrupt_next;
            out_bad_reg     <= out_bad_next;
            out_err_reg     <= out_err_next;
            out_score_reg   <= out_score_next;
            out_count_reg   <= out_count_next;
            out_ovf_reg     <= out_ovf_next;
        end
    end

    assign in_stall         = (state_reg != ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign is_corrupted     = out_corrupt_reg;
    assign bad_closer       = out_bad_reg;
    assign error_score      = out_err_reg;
    assign completion_score = out_score_reg;
    assign open_count       = out_count_reg;
    assign stack_overflow   = out_ovf_reg;

    // The walk never runs past the entries that the line left on the stack.
    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (walk_cnt_reg <= level_reg))
        else $error("score walk count exceeds the stack level");

    a_walk_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (walk_cnt_reg != '0) |-> (state_reg == ST_WALK))
        else $error("score walk count nonzero outside the walk");

    a_level_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg <= DEPTH_L))
        else $error("stack level exceeds the stack depth");

    a_corrupt_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && corrupt_reg) |-> (walk_cnt_reg == '0))
        else $error("score walk runs on a corrupted line");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && walk_cnt_reg == '0 && !(out_valid_reg && out_stall))
        |=> (level_reg == '0 && !corrupt_reg && out_valid_reg && state_reg == ST_IDLE))
        else $error("line end did not load the result and clear the line state");

endmodule

FILE: tb/bmc_line_monitor.sv
// ----------------------------------------------------------------------------
// bmc_line_monitor: predicts and checks the line results of the bracket checker
// Watches both channels, tracks the opener stack of the current line for every
// accepted input transaction, and compares each accepted result transaction
// field by field with the oldest pending line verdict.
// ----------------------------------------------------------------------------
module bmc_line_monitor
    import bmc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [7:0]             char_in,
    input  logic                   line_end,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic                   is_corrupted,
    input  logic [1:0]             bad_closer,
    input  logic [ERR_SCORE_W-1:0] error_score,
    input  logic [SCORE_W-1:0]     completion_score,
    input  logic [COUNT_W-1:0]     open_count,
    input  logic                   stack_overflow,
    output int                     mismatch_count,
    output int                     lines_in_flight
);

    typedef struct packed {
        logic                   corrupt;
        kind_t                  bad;
        logic [ERR_SCORE_W-1:0] err;
        logic [SCORE_W-1:0]     score;
        logic [COUNT_W-1:0]     open;
        logic                   lost;
    } line_verdict_t;

    line_verdict_t verdicts_due[$];
    line_verdict_t want_v;
    kind_t         opener_stack [STACK_DEPTH];
    int            stack_level;
    logic          corrupt_seen;
    kind_t         first_bad;
    logic          push_lost;
    int            results_seen;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("bmc mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic advance_line(input logic [7:0] c, input logic is_last);
        logic               is_open;
        logic               is_close;
        kind_t              k;
        line_verdict_t      v;
        logic [SCORE_W-1:0] s;
        int                 i;
        is_open  = 1'b0;
        is_close = 1'b0;
        k        = KIND_PAREN;
        case (c)
            CHAR_OPEN_PAREN:
            begin
                is_open = 1'b1;
                k       = KIND_PAREN;
            end
            CHAR_OPEN_SQUARE:
            begin
                is_open = 1'b1;
                k       = KIND_SQUARE;
            end
            CHAR_OPEN_CURLY:
            begin
                is_open = 1'b1;
                k       = KIND_CURLY;
            end
            CHAR_OPEN_ANGLE:
            begin
                is_open = 1'b1;
                k       = KIND_ANGLE;
            end
            CHAR_CLOSE_PAREN:
            begin
                is_close = 1'b1;
                k        = KIND_PAREN;
            end
            CHAR_CLOSE_SQUARE:
            begin
                is_close = 1'b1;
                k        = KIND_SQUARE;
            end
            CHAR_CLOSE_CURLY:
            begin
                is_close = 1'b1;
                k        = KIND_CURLY;
            end
            CHAR_CLOSE_ANGLE:
            begin
                is_close = 1'b1;
                k        = KIND_ANGLE;
            end
            default:
            begin
                is_open  = 1'b0;
                is_close = 1'b0;
            end
        endcase

        if (!corrupt_seen)
        begin
            if (is_open)
            begin
                if (stack_level < STACK_DEPTH)
                begin
                    opener_stack[stack_level] = k;
                    stack_level++;
                end
                else
                begin
                    push_lost = 1'b1;
                end
            end
            else if (is_close)
            begin
                if (stack_level > 0 && opener_stack[stack_level-1] == k)
                begin
                    stack_level--;
                end
                else
                begin
                    corrupt_seen = 1'b1;
                    first_bad    = k;
                end
            end
        end

        if (is_last)
        begin
            s = '0;
            if (!corrupt_seen)
            begin
                for (i = stack_level; i > 0; i--)
                begin
                    s = s * 64'd5 + SCORE_W'(opener_stack[i-1]) + 64'd1;
                end
            end
            v         = '0;
            v.corrupt = corrupt_seen;
            v.bad     = corrupt_seen ? first_bad : KIND_PAREN;
            if (corrupt_seen)
            begin
                case (first_bad)
                    KIND_PAREN:  v.err = SCORE_PAREN;
                    KIND_SQUARE: v.err = SCORE_SQUARE;
                    KIND_CURLY:  v.err = SCORE_CURLY;
                    default:     v.err = SCORE_ANGLE;
                endcase
            end
            v.score = s;
            v.open  = COUNT_W'(stack_level);
            v.lost  = push_lost;
            verdicts_due = {verdicts_due, v};
            stack_level  = 0;
            corrupt_seen = 1'b0;
            first_bad    = KIND_PAREN;
            push_lost    = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdicts_due.delete();
            stack_level     = 0;
            corrupt_seen    = 1'b0;
            first_bad       = KIND_PAREN;
            push_lost       = 1'b0;
            results_seen    = 0;
            mismatch_count  = 0;
            lines_in_flight = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_line(char_in, line_end);
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (verdicts_due.size() == 0)
                begin
                    report_mismatch("result with no line pending", 64'd0, 64'd0);
                end
                else
                begin
                    want_v = verdicts_due.pop_front();
                    if (is_corrupted !== want_v.corrupt)
                        report_mismatch("is_corrupted", 64'(is_corrupted),
                                        64'(want_v.corrupt));
                    if (bad_closer !== want_v.bad)
                        report_mismatch("bad_closer", 64'(bad_closer), 64'(want_v.bad));
                    if (error_score !== want_v.err)
                        report_mismatch("error_score", 64'(error_score), 64'(want_v.err));
                    if (completion_score !== want_v.score)
                        report_mismatch("completion_score", completion_score,
                                        want_v.score);
                    if (open_count !== want_v.open)
                        report_mismatch("open_count", 64'(open_count), 64'(want_v.open));
                    if (stack_overflow !== want_v.lost)
                        report_mismatch("stack_overflow", 64'(stack_overflow),
                                        64'(want_v.lost));
                end
            end
            lines_in_flight = verdicts_due.size();
        end
    end

endmodule

FILE: tb/bracket_match_checker_tb.sv
// ----------------------------------------------------------------------------
// bracket_match_checker_tb: top level testbench of the bracket match checker
// Sends short directed lines for every bracket kind, several mismatches and the empty-stack
// case, then random lines that are mostly balanced, unfinished or corrupted,
// with noise lines and lines deep enough to fill and overflow the stack.
// Both channels idle in random bursts; a line monitor predicts and checks.
// ----------------------------------------------------------------------------
module bracket_match_checker_tb
    import bmc_pkg::*;
;

    localparam int STACK_DEPTH  = 64;
    localparam int ITEM_TARGET  = 1450;
    localparam int QUIET_TAIL   = 150;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = STACK_DEPTH + 16;

    typedef enum int {
        LINE_BALANCED,
        LINE_OPEN,
        LINE_CORRUPT,
        LINE_NOISE,
        LINE_DEEP
    } line_shape_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             char_in;
    logic                   line_end;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   is_corrupted;
    logic [1:0]             bad_closer;
    logic [ERR_SCORE_W-1:0] error_score;
    logic [SCORE_W-1:0]     completion_score;
    logic [COUNT_W-1:0]     open_count;
    logic                   stack_overflow;
    int                     mismatch_count;
    int                     lines_in_flight;

    logic [7:0]  line_chars[$];
    int          items_sent  = 0;
    int          cycle_count = 0;
    int          stall_left  = 0;
    int          run_left    = 0;
    logic        quiet       = 1'b0;
    logic        paused      = 1'b0;
    int          gap_pct;
    int          pick;
    line_shape_t shape;

    bracket_match_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_in          (char_in),
        .line_end         (line_end),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .is_corrupted     (is_corrupted),
        .bad_closer       (bad_closer),
        .error_score      (error_score),
        .completion_score (completion_score),
        .open_count       (open_count),
        .stack_overflow   (stack_overflow)
    );

    bmc_line_monitor #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_line_monitor (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_in          (char_in),
        .line_end         (line_end),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .is_corrupted     (is_corrupted),
        .bad_closer       (bad_closer),
        .error_score      (error_score),
        .completion_score (completion_score),
        .open_count       (open_count),
        .stack_overflow   (stack_overflow),
        .mismatch_count   (mismatch_count),
        .lines_in_flight  (lines_in_flight)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left == 0 && run_left == 0)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                run_left = $urandom_range(1, 60);
            end
            else
            begin
                stall_left = $urandom_range(1, 17);
                run_left   = $urandom_range(1, 8);
            end
        end
        if (quiet)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            run_left--;
        end
    end

    function automatic logic [7:0] opener_char(kind_t k);
        case (k)
            KIND_PAREN:  return CHAR_OPEN_PAREN;
            KIND_SQUARE: return CHAR_OPEN_SQUARE;
            KIND_CURLY:  return CHAR_OPEN_CURLY;
            default:     return CHAR_OPEN_ANGLE;
        endcase
    endfunction

    function automatic logic [7:0] closer_char(kind_t k);
        case (k)
            KIND_PAREN:  return CHAR_CLOSE_PAREN;
            KIND_SQUARE: return CHAR_CLOSE_SQUARE;
            KIND_CURLY:  return CHAR_CLOSE_CURLY;
            default:     return CHAR_CLOSE_ANGLE;
        endcase
    endfunction

    function automatic void load_text(string s);
        int i;
        line_chars.delete();
        for (i = 0; i < s.len(); i++)
        begin
            line_chars = {line_chars, s[i]};
        end
    endfunction

    task automatic build_line(input line_shape_t kind_of_line, input int deep_opens);
        kind_t pend[$];
        kind_t k;
        int    len;
        int    bad_at;
        int    i;
        int    r;
        int    n;
        line_chars.delete();
        if (kind_of_line == LINE_DEEP)
        begin
            for (i = 0; i < deep_opens; i++)
            begin
                k = kind_t'($urandom_range(0, 3));
                line_chars = {line_chars, opener_char(k)};
                pend       = {pend, k};
            end
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    line_chars = {line_chars, 8'($urandom_range(0, 255))};
                end
                else
                begin
                    k = pend[$];
                    pend.delete(pend.size() - 1);
                    line_chars = {line_chars, closer_char(k)};
                end
            end
        end
        else if (kind_of_line == LINE_NOISE)
        begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++)
            begin
                line_chars = {line_chars, 8'($urandom_range(0, 255))};
            end
        end
        else
        begin
            len    = $urandom_range(1, 20);
            bad_at = (kind_of_line == LINE_CORRUPT) ? $urandom_range(0, len - 1) : -1;
            for (i = 0; i < len; i++)
            begin
                r = $urandom_range(0, 99);
                if (i == bad_at)
                begin
                    if (pend.size() == 0)
                        k = kind_t'($urandom_range(0, 3));
                    else
                        k = pend[$] + kind_t'($urandom_range(1, 3));
                    line_chars = {line_chars, closer_char(k)};
                end
                else if (r < 8)
                begin
                    line_chars = {line_chars, 8'($urandom_range(0, 255))};
                end
                else if (pend.size() == 0 || (r < 55 && pend.size() < 40))
                begin
                    k = kind_t'($urandom_range(0, 3));
                    line_chars = {line_chars, opener_char(k)};
                    pend       = {pend, k};
                end
                else
                begin
                    k = pend[$];
                    pend.delete(pend.size() - 1);
                    line_chars = {line_chars, closer_char(k)};
                end
            end
            if (kind_of_line == LINE_BALANCED)
            begin
                while (pend.size() > 0)
                begin
                    k = pend[$];
                    pend.delete(pend.size() - 1);
                    line_chars = {line_chars, closer_char(k)};
                end
            end
        end
        if (line_chars.size() == 0)
        begin
            line_chars = {line_chars, 8'($urandom_range(0, 255))};
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic is_last, input int pct);
        int n;
        if (!quiet && $urandom_range(0, 99) < pct)
        begin
            n = $urandom_range(1, 17);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        char_in  <= c;
        line_end <= is_last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_line(input int pct);
        int i;
        for (i = 0; i < line_chars.size(); i++)
        begin
            send_char(line_chars[i], i == line_chars.size() - 1, pct);
        end
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (lines_in_flight != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        char_in  = 8'h00;
        line_end = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        load_text("([{<>}])");
        send_line(0);
        load_text(")");
        send_line(30);
        load_text("(]))");
        send_line(0);
        load_text("[}");
        send_line(50);
        load_text("{>");
        send_line(0);
        load_text("<{");
        send_line(0);
        line_chars = '{8'h00};
        send_line(0);
        line_chars = '{8'hFF};
        send_line(0);
        load_text("a(");
        send_line(20);
        wait_all_results();

        build_line(LINE_DEEP, STACK_DEPTH);
        send_line(10);
        build_line(LINE_DEEP, $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 8));
        send_line(10);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent > ITEM_TARGET - QUIET_TAIL)
                quiet = 1'b1;
            if (!paused && items_sent > ITEM_TARGET / 2)
            begin
                wait_all_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
                shape = LINE_BALANCED;
            else if (pick < 65)
                shape = LINE_OPEN;
            else if (pick < 88)
                shape = LINE_CORRUPT;
            else if (pick < 95)
                shape = LINE_NOISE;
            else
                shape = LINE_DEEP;
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            build_line(shape, $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 8));
            send_line(gap_pct);
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
src/bmc_pkg.sv
src/bmc_cell.sv
src/bmc_stack.sv
src/bracket_match_checker.sv
tb/bmc_line_monitor.sv
tb/bracket_match_checker_tb.sv
